// ----- rtl/b64sd_pkg.sv -----
`timescale 1ns / 1ps
package b64sd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIXTY_TWO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIXTY_THREE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAD         = 2'd2;

  localparam logic [7:0] CHAR_SIXTY_TWO_RST   = 8'd43;
  localparam logic [7:0] CHAR_SIXTY_THREE_RST = 8'd47;
  localparam logic [7:0] PAD_CHAR_RST         = 8'd61;

  localparam logic [7:0] DIG_INVALID = 8'd255;
  localparam logic [6:0] DIG_SIXTY_TWO   = 7'd62;
  localparam logic [6:0] DIG_SIXTY_THREE = 7'd63;
  localparam logic [6:0] DIG_PAD         = 7'd64;
  localparam logic [6:0] DIG_LOWER_BASE  = 7'd26;
  localparam logic [6:0] DIG_DECIMAL_BASE = 7'd52;

  typedef logic [6:0] digit_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [2:0] bytes;
    logic [1:0]  nb;
    logic        last;
    logic        inv;
  } job_t;

  typedef struct packed {
    byte_t [2:0] bytes;
    logic [1:0]  nb;
  } grp_t;

  function automatic logic is_space(input byte_t c);
    is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic byte_t map_digit(input byte_t c, input byte_t c62,
                                      input byte_t c63, input byte_t pad);
    byte_t r;
    r = DIG_INVALID;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h61 + {1'b0, DIG_LOWER_BASE};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + {1'b0, DIG_DECIMAL_BASE};
    end else if (c == c62) begin
      r = {1'b0, DIG_SIXTY_TWO};
    end else if (c == c63) begin
      r = {1'b0, DIG_SIXTY_THREE};
    end else if (c == pad) begin
      r = {1'b0, DIG_PAD};
    end
    map_digit = r;
  endfunction

  // bytes from the front of a group of n digits, up to the first digit above 63
  function automatic grp_t group_bytes(input digit_t [3:0] d, input logic [2:0] n);
    grp_t g;
    g = '0;
    if (n >= 3'd2 && !d[0][6] && !d[1][6]) begin
      g.bytes[0] = {d[0][5:0], d[1][5:4]};
      g.nb = 2'd1;
      if (n >= 3'd3 && !d[2][6]) begin
        g.bytes[1] = {d[1][3:0], d[2][5:2]};
        g.nb = 2'd2;
        if (n >= 3'd4 && !d[3][6]) begin
          g.bytes[2] = {d[2][1:0], d[3][5:0]};
          g.nb = 2'd3;
        end
      end
    end
    group_bytes = g;
  endfunction

endpackage

// ----- rtl/b64sd_front.sv -----
`timescale 1ns / 1ps
module b64sd_front import b64sd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 accept,
  input  logic [7:0]           ch,
  input  logic                 is_last,
  output logic                 push,
  output job_t                 push_job
);

  byte_t      c62_r, c63_r, pad_r;
  digit_t     held_r [3];
  digit_t     held_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       stopped_r, stopped_nxt;

  byte_t        dig;
  logic         act, inval;
  digit_t [3:0] wdig;
  logic [2:0]   n;
  grp_t         grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c62_r <= CHAR_SIXTY_TWO_RST;
      c63_r <= CHAR_SIXTY_THREE_RST;
      pad_r <= PAD_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SIXTY_TWO:   c62_r <= cfg_wdata;
        CFG_IDX_SIXTY_THREE: c63_r <= cfg_wdata;
        CFG_IDX_PAD:         pad_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    dig   = map_digit(ch, c62_r, c63_r, pad_r);
    act   = !stopped_r && !is_space(ch);
    inval = (dig == DIG_INVALID);
    cnt_nxt     = cnt_r;
    stopped_nxt = stopped_r;
    for (int i = 0; i < 3; i++) begin
      held_nxt[i] = held_r[i];
    end
    n = 3'd0;
    if (act && inval) begin
      n           = {1'b0, cnt_r};
      cnt_nxt     = 2'd0;
      stopped_nxt = 1'b1;
    end else if (act && cnt_r == 2'd3) begin
      n       = 3'd4;
      cnt_nxt = 2'd0;
    end else if (act) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt_r == 2'(i)) held_nxt[i] = dig[6:0];
      end
      cnt_nxt = cnt_r + 2'd1;
      if (is_last) n = {1'b0, cnt_nxt};
    end else if (is_last) begin
      n = {1'b0, cnt_r};
    end
    for (int i = 0; i < 3; i++) begin
      wdig[i] = held_nxt[i];
    end
    wdig[3] = dig[6:0];
    grp = group_bytes(wdig, n);

    push_job.bytes = grp.bytes;
    push_job.nb    = grp.nb;
    push_job.last  = is_last;
    push_job.inv   = stopped_nxt;
    push = accept && (is_last || grp.nb != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 2'd0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      cnt_r     <= is_last ? 2'd0 : cnt_nxt;
      stopped_r <= is_last ? 1'b0 : stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/b64sd_queue.sv -----
`timescale 1ns / 1ps
module b64sd_queue import b64sd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- rtl/b64sd_back.sv -----
`timescale 1ns / 1ps
module b64sd_back import b64sd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_done_res,
  output logic       out_stopped_invalid
);

  logic [1:0] k_r, k_nxt;
  logic [1:0] nres_m1;
  logic       fin;

  always_comb begin
    nres_m1 = (head_job.nb == 2'd0) ? 2'd0 : head_job.nb - 2'd1;
    fin     = (k_r == nres_m1);

    out_valid           = head_valid;
    out_byte_valid      = (k_r < head_job.nb);
    out_data_byte       = out_byte_valid ? head_job.bytes[k_r] : 8'd0;
    out_run_last        = fin;
    out_done_res        = fin && head_job.last;
    out_stopped_invalid = fin && head_job.last && head_job.inv;

    pop   = head_valid && !out_stall && fin;
    k_nxt = k_r;
    if (head_valid && !out_stall) k_nxt = fin ? 2'd0 : k_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 2'd0;
    end else begin
      k_r <= k_nxt;
    end
  end

endmodule

// ----- rtl/base64_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// Streaming Base64 decoder. One character is taken per cycle while the result queue
// (QDEPTH entries, one per character that causes results) has room; whitespace is skipped
// and the digit set for 62, 63 and padding comes from three registers written over the cfg
// port, by the user only while idle; the block does not enforce it. Results leave one per
// cycle while out_stall is low, the first in the cycle after its character is taken at the
// earliest, so a character that completes a group can hold the output side for up to three
// results, absorbed by the queue between classifier and output sequencer. No run of
// characters causes more than one result per character on average, so with no output stall
// the input takes a character every cycle and in_stall rises only when out_stall backs the
// queue up. A message's last result has done_res, and stopped_invalid on a bad character.
module base64_stream_decoder_unit import b64sd_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_ch,
  input  logic                 in_is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_data_byte,
  output logic                 out_byte_valid,
  output logic                 out_run_last,
  output logic                 out_done_res,
  output logic                 out_stopped_invalid
);

  logic accept, push, pop, full, head_valid;
  job_t push_job, head_job;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  b64sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .ch        (in_ch),
    .is_last   (in_is_last),
    .push      (push),
    .push_job  (push_job)
  );

  b64sd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64sd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_byte_valid      (out_byte_valid),
    .out_run_last        (out_run_last),
    .out_done_res        (out_done_res),
    .out_stopped_invalid (out_stopped_invalid)
  );

endmodule

// ----- rtl/b64sd_checker.sv -----
`timescale 1ns / 1ps
module b64sd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_run_last,
  input logic       out_done_res,
  input logic       out_stopped_invalid
);

  // a message ends on the last result of its final transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_run_last)
    else $error("done without run_last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped_invalid |-> out_done_res)
    else $error("stopped_invalid without done");

  // a result with no byte only ever closes a message
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_run_last && out_done_res && out_data_byte == 8'd0)
    else $error("empty result not final");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_run_last))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder_unit b64sd_checker u_chk (.*);
